// ===== rtl/core/srtu_pkg.sv =====
package srtu_pkg;

	localparam int unsigned IN_TDATA_W  = 152;
	localparam int unsigned OUT_TDATA_W = 72;
	localparam int unsigned RES_W       = 68;

	localparam logic [3:0] REQ_TRAP     = 4'd0;
	localparam logic [3:0] REQ_SYSCALL  = 4'd1;
	localparam logic [3:0] REQ_RFI      = 4'd2;
	localparam logic [3:0] REQ_MTCRF    = 4'd3;
	localparam logic [3:0] REQ_MCRXR    = 4'd4;
	localparam logic [3:0] REQ_MFCR     = 4'd5;
	localparam logic [3:0] REQ_MTMSR    = 4'd6;
	localparam logic [3:0] REQ_MFMSR    = 4'd7;
	localparam logic [3:0] REQ_MTSR     = 4'd8;
	localparam logic [3:0] REQ_MFSR     = 4'd9;
	localparam logic [3:0] REQ_WR_SRR0  = 4'd10;
	localparam logic [3:0] REQ_WR_SRR1  = 4'd11;
	localparam logic [3:0] REQ_WR_XER   = 4'd12;

	localparam logic [1:0] EXC_NONE     = 2'd0;
	localparam logic [1:0] EXC_TRAP     = 2'd1;
	localparam logic [1:0] EXC_PRIV     = 2'd2;
	localparam logic [1:0] EXC_SYSCALL  = 2'd3;

	localparam logic [4:0] TO_LT        = 5'h10;
	localparam logic [4:0] TO_GT        = 5'h08;
	localparam logic [4:0] TO_EQ        = 5'h04;
	localparam logic [4:0] TO_LTU       = 5'h02;
	localparam logic [4:0] TO_GTU       = 5'h01;

	localparam logic [31:0] MSR_PR_BIT    = 32'h0000_4000;
	localparam logic [31:0] RFI_KEEP_MASK = 32'h87C0_FF73;
	localparam logic [31:0] RFI_CLR_EXTRA = 32'h0004_0000;
	localparam logic [31:0] XER_FLAGS     = 32'hF000_0000;
	localparam logic [3:0]  NIBBLE        = 4'hF;
	localparam logic [31:0] PC_STEP       = 32'd4;

	typedef struct packed {
		logic        [31:0] current_pc;
		logic        [3:0]  segment_index;
		logic        [2:0]  field_select;
		logic        [7:0]  field_mask;
		logic        [31:0] source_value;
		logic        [4:0]  trap_conditions;
		logic signed [31:0] operand_b;
		logic signed [31:0] operand_a;
		logic        [3:0]  req_type;
	} in_item_t;

	typedef struct packed {
		logic        pc_redirect;
		logic [31:0] next_pc;
		logic [1:0]  exception_code;
		logic        read_valid;
		logic [31:0] read_value;
	} result_t;

	typedef struct packed {
		logic [31:0] cr;
		logic [31:0] msr;
		logic [31:0] srr0;
		logic [31:0] srr1;
		logic [31:0] xer;
	} arch_state_t;

	typedef struct packed {
		logic        cr_we;
		logic [31:0] cr_d;
		logic        msr_we;
		logic [31:0] msr_d;
		logic        srr0_we;
		logic        srr1_we;
		logic        xer_we;
		logic [31:0] xer_d;
		logic        seg_we;
	} state_upd_t;

endpackage

// ===== rtl/core/srtu_state.sv =====
module srtu_state #(
	parameter int unsigned SEGMENT_COUNT = 16,
	parameter int unsigned SEG_IDX_W     = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       commit,
	input  srtu_pkg::state_upd_t       upd,
	input  logic [31:0]                wdata,
	input  logic [SEG_IDX_W-1:0]       seg_idx,
	output srtu_pkg::arch_state_t      st,
	output logic [31:0]                seg_rdata
);

	logic [31:0] cr_q;
	logic [31:0] msr_q;
	logic [31:0] srr0_q;
	logic [31:0] srr1_q;
	logic [31:0] xer_q;
	logic [31:0] seg_q [SEGMENT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q   <= '0;
			msr_q  <= '0;
			srr0_q <= '0;
			srr1_q <= '0;
			xer_q  <= '0;
			for (int i = 0; i < SEGMENT_COUNT; i++) begin
				seg_q[i] <= '0;
			end
		end else if (commit) begin
			if (upd.cr_we) begin
				cr_q <= upd.cr_d;
			end
			if (upd.msr_we) begin
				msr_q <= upd.msr_d;
			end
			if (upd.srr0_we) begin
				srr0_q <= wdata;
			end
			if (upd.srr1_we) begin
				srr1_q <= wdata;
			end
			if (upd.xer_we) begin
				xer_q <= upd.xer_d;
			end
			if (upd.seg_we) begin
				seg_q[seg_idx] <= wdata;
			end
		end
	end

	assign st.cr   = cr_q;
	assign st.msr  = msr_q;
	assign st.srr0 = srr0_q;
	assign st.srr1 = srr1_q;
	assign st.xer  = xer_q;
	assign seg_rdata = seg_q[seg_idx];

endmodule

// ===== rtl/core/srtu_exec.sv =====
module srtu_exec (
	input  srtu_pkg::in_item_t    item,
	input  srtu_pkg::arch_state_t st,
	input  logic [31:0]           seg_rdata,
	output srtu_pkg::result_t     res,
	output srtu_pkg::state_upd_t  upd
);

	logic        priv;
	logic        lt_s;
	logic        gt_s;
	logic        eq;
	logic        lt_u;
	logic        gt_u;
	logic        trap_hit;
	logic [31:0] crm_mask;
	logic [4:0]  xer_shift;
	logic [31:0] xer_mask;
	logic [31:0] pc_inc;

	assign priv = (st.msr & srtu_pkg::MSR_PR_BIT) != '0;
	assign lt_s = item.operand_a < item.operand_b;
	assign gt_s = item.operand_a > item.operand_b;
	assign eq   = item.operand_a == item.operand_b;
	assign lt_u = $unsigned(item.operand_a) < $unsigned(item.operand_b);
	assign gt_u = $unsigned(item.operand_a) > $unsigned(item.operand_b);

	assign trap_hit = (lt_s && (item.trap_conditions & srtu_pkg::TO_LT)  != '0)
		|| (gt_s && (item.trap_conditions & srtu_pkg::TO_GT)  != '0)
		|| (eq   && (item.trap_conditions & srtu_pkg::TO_EQ)  != '0)
		|| (lt_u && (item.trap_conditions & srtu_pkg::TO_LTU) != '0)
		|| (gt_u && (item.trap_conditions & srtu_pkg::TO_GTU) != '0);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			crm_mask[i*4 +: 4] = item.field_mask[i] ? srtu_pkg::NIBBLE : 4'h0;
		end
	end

	assign xer_shift = {item.field_select, 2'b00};
	assign xer_mask  = srtu_pkg::XER_FLAGS >> xer_shift;
	assign pc_inc    = item.current_pc + srtu_pkg::PC_STEP;

	always_comb begin
		res = '0;
		upd = '0;
		case (item.req_type)
			srtu_pkg::REQ_TRAP: begin
				if (trap_hit) begin
					res.exception_code = srtu_pkg::EXC_TRAP;
					res.next_pc        = pc_inc;
					res.pc_redirect    = 1'b1;
				end
			end
			srtu_pkg::REQ_SYSCALL: begin
				res.exception_code = srtu_pkg::EXC_SYSCALL;
				res.next_pc        = pc_inc;
				res.pc_redirect    = 1'b1;
			end
			srtu_pkg::REQ_RFI: begin
				upd.msr_we = 1'b1;
				upd.msr_d  = (st.msr & ~(srtu_pkg::RFI_KEEP_MASK | srtu_pkg::RFI_CLR_EXTRA))
					| (st.srr1 & srtu_pkg::RFI_KEEP_MASK);
				res.next_pc     = {st.srr0[31:2], 2'b00};
				res.pc_redirect = 1'b1;
			end
			srtu_pkg::REQ_MTCRF: begin
				upd.cr_we = 1'b1;
				upd.cr_d  = (item.source_value & crm_mask) | (st.cr & ~crm_mask);
			end
			srtu_pkg::REQ_MCRXR: begin
				upd.cr_we  = 1'b1;
				upd.cr_d   = (st.cr & ~xer_mask)
					| ((st.xer & srtu_pkg::XER_FLAGS) >> xer_shift);
				upd.xer_we = 1'b1;
				upd.xer_d  = st.xer & ~srtu_pkg::XER_FLAGS;
			end
			srtu_pkg::REQ_MFCR: begin
				res.read_value = st.cr;
				res.read_valid = 1'b1;
			end
			srtu_pkg::REQ_MTMSR: begin
				if (priv) begin
					res.exception_code = srtu_pkg::EXC_PRIV;
				end else begin
					upd.msr_we = 1'b1;
					upd.msr_d  = item.source_value;
				end
			end
			srtu_pkg::REQ_MFMSR: begin
				if (priv) begin
					res.exception_code = srtu_pkg::EXC_PRIV;
				end else begin
					res.read_value = st.msr;
					res.read_valid = 1'b1;
				end
			end
			srtu_pkg::REQ_MTSR: begin
				if (priv) begin
					res.exception_code = srtu_pkg::EXC_PRIV;
				end else begin
					upd.seg_we = 1'b1;
				end
			end
			srtu_pkg::REQ_MFSR: begin
				if (priv) begin
					res.exception_code = srtu_pkg::EXC_PRIV;
				end else begin
					res.read_value = seg_rdata;
					res.read_valid = 1'b1;
				end
			end
			srtu_pkg::REQ_WR_SRR0: begin
				upd.srr0_we = 1'b1;
			end
			srtu_pkg::REQ_WR_SRR1: begin
				upd.srr1_we = 1'b1;
			end
			srtu_pkg::REQ_WR_XER: begin
				upd.xer_we = 1'b1;
				upd.xer_d  = item.source_value;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/powerpc_system_register_trap_unit.sv =====
// An accepted input transaction is held in the input register, executed combinationally
// there, and its result is loaded into the result register that drives m_tdata.
// Throughput: one transaction per cycle while the result register is empty or being
// taken; only then does the input register advance, so each item sees all earlier updates.
// Reset (arst_n low) empties both pipeline registers and clears CR, MSR, SRR0,
// SRR1, XER and every segment register to zero.
module powerpc_system_register_trap_unit #(
	parameter int unsigned SEGMENT_COUNT = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// req_type[3:0], operand_a[35:4], operand_b[67:36], trap_conditions[72:68],
	// source_value[104:73], field_mask[112:105], field_select[115:113],
	// segment_index[119:116], current_pc[151:120]
	input  logic [srtu_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// read_value[31:0], read_valid[32], exception_code[34:33], next_pc[66:35],
	// pc_redirect[67], zero fill[71:68]
	output logic [srtu_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int unsigned SEG_IDX_W = $clog2(SEGMENT_COUNT);

	srtu_pkg::in_item_t    item_s1;
	logic                  valid_s1;
	srtu_pkg::result_t     res_q;
	logic                  res_valid_q;
	srtu_pkg::result_t     res_d;
	srtu_pkg::state_upd_t  upd;
	srtu_pkg::arch_state_t st;
	logic [31:0]           seg_rdata;
	logic                  advance;
	logic                  s_fire;

	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			item_s1 <= srtu_pkg::in_item_t'(s_tdata);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	srtu_state #(
		.SEGMENT_COUNT (SEGMENT_COUNT),
		.SEG_IDX_W     (SEG_IDX_W)
	) u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.commit    (advance),
		.upd       (upd),
		.wdata     (item_s1.source_value),
		.seg_idx   (item_s1.segment_index[SEG_IDX_W-1:0]),
		.st        (st),
		.seg_rdata (seg_rdata)
	);

	srtu_exec u_exec (
		.item      (item_s1),
		.st        (st),
		.seg_rdata (seg_rdata),
		.res       (res_d),
		.upd       (upd)
	);

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {{(srtu_pkg::OUT_TDATA_W - srtu_pkg::RES_W){1'b0}}, res_q};

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("result register not loaded after advance");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(item_s1)))
		else $error("stalled input stage lost or changed its item");

	a_priv_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.exception_code == srtu_pkg::EXC_PRIV)
			|-> (!res_q.read_valid && !res_q.pc_redirect))
		else $error("privileged fault reported data or redirect");

	a_mcrxr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.req_type == srtu_pkg::REQ_MCRXR) |=> (st.xer[31:28] == 4'h0))
		else $error("XER flags not cleared after mcrxr");

	a_redirect_pc: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.pc_redirect) |-> (res_q.next_pc == '0))
		else $error("next pc set without redirect");

endmodule

// ===== test/powerpc_system_register_trap_unit_tb.sv =====
module powerpc_system_register_trap_unit_tb;

	localparam int unsigned SEG_N       = 16;
	localparam int unsigned PHASE_ITEMS = 425;
	localparam int unsigned STALL_LIMIT = 1000;
	localparam int unsigned MAX_SHOWN   = 10;
	localparam int unsigned TAIL_CYCLES = 8;
	localparam logic [3:0]  REQ_SPARE_LO = 4'd13;
	localparam logic [3:0]  REQ_SPARE_HI = 4'd15;

	typedef struct packed {
		srtu_pkg::in_item_t op;
		logic               typed;
		srtu_pkg::result_t  want;
	} stim_row_t;

	logic                             clk      = 1'b0;
	logic                             arst_n   = 1'b0;
	logic                             s_tvalid = 1'b0;
	logic                             s_tready;
	logic [srtu_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                             m_tvalid;
	logic                             m_tready = 1'b0;
	logic [srtu_pkg::OUT_TDATA_W-1:0] m_tdata;

	logic [31:0] cr_q   = '0;
	logic [31:0] msr_q  = '0;
	logic [31:0] srr0_q = '0;
	logic [31:0] srr1_q = '0;
	logic [31:0] xer_q  = '0;
	logic [31:0] seg_q [SEG_N];

	srtu_pkg::result_t pending_results [$];
	stim_row_t         stim_table [$];
	int unsigned       mismatches     = 0;
	int unsigned       idle_cycles    = 0;
	int unsigned       send_idle_pct  = 0;
	int unsigned       recv_stall_pct = 0;

	always #1 clk = ~clk;

	powerpc_system_register_trap_unit #(
		.SEGMENT_COUNT(SEG_N)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	function automatic logic trap_fires(logic [31:0] a, logic [31:0] b, logic [4:0] to);
		return (($signed(a) < $signed(b)) && (to & srtu_pkg::TO_LT) != 0) ||
			(($signed(a) > $signed(b)) && (to & srtu_pkg::TO_GT) != 0) ||
			((a == b) && (to & srtu_pkg::TO_EQ) != 0) ||
			((a < b) && (to & srtu_pkg::TO_LTU) != 0) ||
			((a > b) && (to & srtu_pkg::TO_GTU) != 0);
	endfunction

	function automatic srtu_pkg::result_t predict_sysreg(srtu_pkg::in_item_t op);
		srtu_pkg::result_t r;
		logic [31:0]       m;
		logic              pr;
		r  = '0;
		m  = '0;
		pr = (msr_q & srtu_pkg::MSR_PR_BIT) != 0;
		case (op.req_type)
			srtu_pkg::REQ_TRAP: begin
				if (trap_fires(op.operand_a, op.operand_b, op.trap_conditions)) begin
					r.exception_code = srtu_pkg::EXC_TRAP;
					r.next_pc        = op.current_pc + srtu_pkg::PC_STEP;
					r.pc_redirect    = 1'b1;
				end
			end
			srtu_pkg::REQ_SYSCALL: begin
				r.exception_code = srtu_pkg::EXC_SYSCALL;
				r.next_pc        = op.current_pc + srtu_pkg::PC_STEP;
				r.pc_redirect    = 1'b1;
			end
			srtu_pkg::REQ_RFI: begin
				msr_q = (msr_q & ~(srtu_pkg::RFI_KEEP_MASK | srtu_pkg::RFI_CLR_EXTRA))
					| (srr1_q & srtu_pkg::RFI_KEEP_MASK);
				r.next_pc     = {srr0_q[31:2], 2'b00};
				r.pc_redirect = 1'b1;
			end
			srtu_pkg::REQ_MTCRF: begin
				for (int i = 0; i < 8; i++)
					if (op.field_mask[i])
						m[i*4 +: 4] = srtu_pkg::NIBBLE;
				cr_q = (op.source_value & m) | (cr_q & ~m);
			end
			srtu_pkg::REQ_MCRXR: begin
				m     = srtu_pkg::XER_FLAGS >> (op.field_select * 4);
				cr_q  = (cr_q & ~m)
					| ((xer_q & srtu_pkg::XER_FLAGS) >> (op.field_select * 4));
				xer_q = xer_q & ~srtu_pkg::XER_FLAGS;
			end
			srtu_pkg::REQ_MFCR: begin
				r.read_value = cr_q;
				r.read_valid = 1'b1;
			end
			srtu_pkg::REQ_MTMSR: begin
				if (pr)
					r.exception_code = srtu_pkg::EXC_PRIV;
				else
					msr_q = op.source_value;
			end
			srtu_pkg::REQ_MFMSR: begin
				if (pr) begin
					r.exception_code = srtu_pkg::EXC_PRIV;
				end else begin
					r.read_value = msr_q;
					r.read_valid = 1'b1;
				end
			end
			srtu_pkg::REQ_MTSR: begin
				if (pr)
					r.exception_code = srtu_pkg::EXC_PRIV;
				else
					seg_q[op.segment_index] = op.source_value;
			end
			srtu_pkg::REQ_MFSR: begin
				if (pr) begin
					r.exception_code = srtu_pkg::EXC_PRIV;
				end else begin
					r.read_value = seg_q[op.segment_index];
					r.read_valid = 1'b1;
				end
			end
			srtu_pkg::REQ_WR_SRR0: srr0_q = op.source_value;
			srtu_pkg::REQ_WR_SRR1: srr1_q = op.source_value;
			srtu_pkg::REQ_WR_XER:  xer_q  = op.source_value;
			default: ;
		endcase
		return r;
	endfunction

	function automatic srtu_pkg::result_t res(logic [31:0] rv, logic v, logic [1:0] exc,
			logic [31:0] npc, logic redir);
		srtu_pkg::result_t r;
		r.read_value     = rv;
		r.read_valid     = v;
		r.exception_code = exc;
		r.next_pc        = npc;
		r.pc_redirect    = redir;
		return r;
	endfunction

	task automatic table_row(logic [3:0] req, logic [31:0] a, logic [31:0] b, logic [4:0] to,
			logic [31:0] src, logic [7:0] crm, logic [2:0] fsel, logic [3:0] sidx,
			logic [31:0] pc, logic typed, srtu_pkg::result_t want);
		stim_row_t row;
		row.op.req_type        = req;
		row.op.operand_a       = a;
		row.op.operand_b       = b;
		row.op.trap_conditions = to;
		row.op.source_value    = src;
		row.op.field_mask      = crm;
		row.op.field_select    = fsel;
		row.op.segment_index   = sidx;
		row.op.current_pc      = pc;
		row.typed              = typed;
		row.want               = want;
		stim_table.push_back(row);
	endtask

	function automatic logic [31:0] corner_word();
		case ($urandom_range(0, 5))
			0: return 32'h0000_0000;
			1: return 32'h0000_0001;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h7FFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	function automatic srtu_pkg::in_item_t random_sysreg_op();
		srtu_pkg::in_item_t op;
		int unsigned        pick;
		op.operand_a       = $urandom();
		op.operand_b       = $urandom();
		op.trap_conditions = 5'($urandom_range(0, 31));
		op.source_value    = $urandom();
		op.field_mask      = 8'($urandom_range(0, 255));
		op.field_select    = 3'($urandom_range(0, 7));
		op.segment_index   = 4'($urandom_range(0, SEG_N - 1));
		op.current_pc      = $urandom();
		pick = $urandom_range(0, 99);
		if (pick < 16) begin
			op.req_type  = srtu_pkg::REQ_TRAP;
			op.operand_a = corner_word();
			op.operand_b = ($urandom_range(0, 3) == 0) ? op.operand_a : corner_word();
		end else if (pick < 20) begin
			op.req_type = srtu_pkg::REQ_SYSCALL;
		end else if (pick < 26) begin
			op.req_type = srtu_pkg::REQ_RFI;
		end else if (pick < 35) begin
			op.req_type = srtu_pkg::REQ_MTCRF;
		end else if (pick < 41) begin
			op.req_type = srtu_pkg::REQ_MCRXR;
		end else if (pick < 48) begin
			op.req_type = srtu_pkg::REQ_MFCR;
		end else if (pick < 56) begin
			op.req_type = srtu_pkg::REQ_MTMSR;
			if ($urandom_range(0, 3) != 0)
				op.source_value = op.source_value & ~srtu_pkg::MSR_PR_BIT;
		end else if (pick < 63) begin
			op.req_type = srtu_pkg::REQ_MFMSR;
		end else if (pick < 71) begin
			op.req_type = srtu_pkg::REQ_MTSR;
		end else if (pick < 79) begin
			op.req_type = srtu_pkg::REQ_MFSR;
		end else if (pick < 84) begin
			op.req_type = srtu_pkg::REQ_WR_SRR0;
		end else if (pick < 90) begin
			op.req_type = srtu_pkg::REQ_WR_SRR1;
			if ($urandom_range(0, 1) != 0)
				op.source_value = op.source_value & ~srtu_pkg::MSR_PR_BIT;
		end else if (pick < 97) begin
			op.req_type = srtu_pkg::REQ_WR_XER;
		end else begin
			op.req_type = 4'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end
		return op;
	endfunction

	task automatic issue_op(srtu_pkg::in_item_t op, logic typed, srtu_pkg::result_t want);
		srtu_pkg::result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= op;
		do @(posedge clk); while (!s_tready);
		predicted = predict_sysreg(op);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic check_result(srtu_pkg::result_t got);
		srtu_pkg::result_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("unexpected transaction: rv=%h v=%b exc=%0d npc=%h redir=%b",
					got.read_value, got.read_valid, got.exception_code, got.next_pc,
					got.pc_redirect);
		end else begin
			want = pending_results.pop_front();
			if (got.read_value !== want.read_value || got.read_valid !== want.read_valid ||
					got.exception_code !== want.exception_code ||
					got.next_pc !== want.next_pc || got.pc_redirect !== want.pc_redirect) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("mismatch: exp %h/%b/%0d/%h/%b, got %h/%b/%0d/%h/%b",
						want.read_value, want.read_valid, want.exception_code, want.next_pc,
						want.pc_redirect, got.read_value, got.read_valid,
						got.exception_code, got.next_pc, got.pc_redirect);
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata[srtu_pkg::RES_W-1:0]);
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("powerpc_system_register_trap_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < SEG_N; i++)
			seg_q[i] = '0;

		table_row(srtu_pkg::REQ_MFCR,    0, 0, 0, 0, 0, 0, 0, 0, 1,
			res(0, 1, srtu_pkg::EXC_NONE, 0, 0));
		table_row(srtu_pkg::REQ_MFMSR,   0, 0, 0, 0, 0, 0, 0, 0, 1,
			res(0, 1, srtu_pkg::EXC_NONE, 0, 0));
		table_row(srtu_pkg::REQ_SYSCALL, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFC, 1,
			res(0, 0, srtu_pkg::EXC_SYSCALL, 0, 1));
		table_row(srtu_pkg::REQ_TRAP, 0, 0, srtu_pkg::TO_EQ, 0, 0, 0, 0, 0, 1,
			res(0, 0, srtu_pkg::EXC_TRAP, 4, 1));
		table_row(srtu_pkg::REQ_TRAP, 32'h8000_0000, 32'h7FFF_FFFF, srtu_pkg::TO_LT, 0, 0, 0,
			0, 32'h100, 1, res(0, 0, srtu_pkg::EXC_TRAP, 32'h104, 1));
		table_row(srtu_pkg::REQ_TRAP, 32'h8000_0000, 32'h7FFF_FFFF,
			srtu_pkg::TO_LTU | srtu_pkg::TO_GT, 0, 0, 0, 0, 32'h100, 1,
			res(0, 0, srtu_pkg::EXC_NONE, 0, 0));
		table_row(srtu_pkg::REQ_TRAP, 32'h8000_0000, 32'h7FFF_FFFF, srtu_pkg::TO_GTU, 0, 0, 0,
			0, 32'h7FFF_FFFC, 1, res(0, 0, srtu_pkg::EXC_TRAP, 32'h8000_0000, 1));
		table_row(srtu_pkg::REQ_TRAP, 32'hFFFF_FFFF, 1,
			srtu_pkg::TO_GT | srtu_pkg::TO_LTU | srtu_pkg::TO_EQ, 0, 0, 0, 0, 0, 1,
			res(0, 0, srtu_pkg::EXC_NONE, 0, 0));
		table_row(srtu_pkg::REQ_TRAP, 32'hFFFF_FFFF, 1,
			srtu_pkg::TO_LT | srtu_pkg::TO_GT | srtu_pkg::TO_EQ | srtu_pkg::TO_LTU
			| srtu_pkg::TO_GTU, 0, 0, 0, 0, 32'hFFFF_FFF8, 0, '0);
		table_row(srtu_pkg::REQ_MTCRF,   0, 0, 0, 32'hFFFF_FFFF, 8'h81, 0, 0, 0, 0, '0);
		table_row(srtu_pkg::REQ_WR_XER,  0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, '0);
		table_row(srtu_pkg::REQ_MCRXR,   0, 0, 0, 0, 0, 3'd7, 0, 0, 0, '0);
		table_row(srtu_pkg::REQ_MCRXR,   0, 0, 0, 0, 0, 3'd0, 0, 0, 0, '0);
		table_row(srtu_pkg::REQ_MFCR,    0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
		table_row(srtu_pkg::REQ_WR_SRR0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, '0);
		table_row(srtu_pkg::REQ_WR_SRR1, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, '0);
		table_row(srtu_pkg::REQ_RFI,     0, 0, 0, 0, 0, 0, 0, 0, 1,
			res(0, 0, srtu_pkg::EXC_NONE, 32'hFFFF_FFFC, 1));
		table_row(srtu_pkg::REQ_MFMSR,   0, 0, 0, 0, 0, 0, 0, 0, 1,
			res(0, 0, srtu_pkg::EXC_PRIV, 0, 0));
		table_row(srtu_pkg::REQ_MTMSR,   0, 0, 0, 0, 0, 0, 0, 0, 1,
			res(0, 0, srtu_pkg::EXC_PRIV, 0, 0));
		table_row(srtu_pkg::REQ_MFSR,    0, 0, 0, 0, 0, 0, 4'd15, 0, 1,
			res(0, 0, srtu_pkg::EXC_PRIV, 0, 0));
		table_row(srtu_pkg::REQ_WR_SRR1, 0, 0, 0, 0, 0, 0, 0, 0, 1, '0);
		table_row(srtu_pkg::REQ_RFI,     0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
		table_row(srtu_pkg::REQ_MTSR,    0, 0, 0, 32'hA5A5_5A5A, 0, 0, 4'd15, 0, 0, '0);
		table_row(srtu_pkg::REQ_MFSR,    0, 0, 0, 0, 0, 0, 4'd15, 0, 0, '0);
		table_row(srtu_pkg::REQ_MTMSR,   0, 0, 0, 32'hFFFF_BFFF, 0, 0, 0, 0, 0, '0);
		table_row(srtu_pkg::REQ_MFMSR,   0, 0, 0, 0, 0, 0, 0, 0, 0, '0);
		table_row(REQ_SPARE_HI, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'h1F, 32'hFFFF_FFFF, 8'hFF,
			3'd7, 4'd15, 32'hFFFF_FFFF, 1, res(0, 0, srtu_pkg::EXC_NONE, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i])
			issue_op(stim_table[i].op, stim_table[i].typed, stim_table[i].want);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct  = (ph == 1) ? 88 : (ph == 3) ? 18 : 0;
			recv_stall_pct = (ph == 2) ? 88 : (ph == 3) ? 18 : 0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				issue_op(random_sysreg_op(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("powerpc_system_register_trap_unit_tb: done, clean");
		else
			$display("powerpc_system_register_trap_unit_tb: done, errors");
		$finish;
	end

endmodule
